@@ rtl/sxrfd_pkg.sv @@
`default_nettype none
package sxrfd_pkg;

   localparam int MAX_WORDS = 32;
   localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [7:0] BYTE_SOX = 8'hf0;
   localparam logic [7:0] BYTE_EOX = 8'hf7;
   localparam logic [7:0] HDR_LEN = 8'd5;

   typedef enum logic [2:0] {
      KIND_REG        = 3'd0,
      KIND_RAW        = 3'd1,
      KIND_EMPTY      = 3'd2,
      KIND_BAD        = 3'd3,
      KIND_LONG       = 3'd4,
      KIND_INCOMPLETE = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [6:0]         sub_id;
      logic [CNT_W-1:0]   count;
   } cmd_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [31:0]        data;
   } wr_type;

   function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = 8'hf0;
         3'd1: b = 8'h00;
         3'd2: b = 8'h20;
         3'd3: b = 8'h0d;
         3'd4: b = 8'h10;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

@@ rtl/sxrfd_front.sv @@
`default_nettype none
module sxrfd_front
   import sxrfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   output logic            push,
   output cmd_type         push_cmd,
   input  wire logic       q_full,
   input  wire logic       drain_done,
   output wr_type          wr,
   output logic            busy
);

   logic [CNT_W-1:0] wc_ff, wc_in;
   logic [7:0]       bc_ff, bc_in;
   logic             hok_ff, hok_in;
   logic [6:0]       sub_ff, sub_in;
   logic [31:0]      acc_ff, acc_in;
   logic [2:0]       pos_ff, pos_in;
   logic             ovf_ff, ovf_in;
   logic             busy_ff, busy_in;
   logic             accept;
   logic [6:0]       lo7;
   logic [31:0]      acc_next;

   assign req_stall = busy_ff || q_full;
   assign accept = req_valid && !req_stall;
   assign lo7 = req_data_byte[6:0];
   assign busy = busy_ff;

   always_comb begin
      unique case (pos_ff)
         3'd0: acc_next = acc_ff | {25'd0, lo7};
         3'd1: acc_next = acc_ff | {18'd0, lo7, 7'd0};
         3'd2: acc_next = acc_ff | {11'd0, lo7, 14'd0};
         3'd3: acc_next = acc_ff | {4'd0, lo7, 21'd0};
         default: acc_next = acc_ff | {lo7[3:0], 28'd0};
      endcase
   end

   always_comb begin
      wc_in = wc_ff;
      bc_in = bc_ff;
      hok_in = hok_ff;
      sub_in = sub_ff;
      acc_in = acc_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      busy_in = busy_ff;
      push = 1'b0;
      push_cmd = '{kind: KIND_BAD, sub_id: sub_ff, count: '0};
      wr = '{en: 1'b0, addr: wc_ff[IDX_W-1:0], data: acc_next};
      if (drain_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         priority if (req_data_byte == BYTE_SOX) begin
            if (bc_ff != 8'd0 || ovf_ff) begin
               push = 1'b1;
               push_cmd.kind = KIND_INCOMPLETE;
            end
            wc_in = '0;
            bc_in = 8'd1;
            hok_in = 1'b1;
            sub_in = 7'd0;
            acc_in = 32'd0;
            pos_in = 3'd0;
            ovf_in = 1'b0;
         end else if (ovf_ff) begin
            if (req_data_byte == BYTE_EOX) begin
               wc_in = '0;
               bc_in = 8'd0;
               hok_in = 1'b1;
               sub_in = 7'd0;
               acc_in = 32'd0;
               pos_in = 3'd0;
               ovf_in = 1'b0;
            end
         end else if (req_data_byte == BYTE_EOX) begin
            push = 1'b1;
            priority if (!hok_ff || bc_ff < HDR_LEN + 8'd1 || pos_ff != 3'd0) begin
               push_cmd.kind = KIND_BAD;
            end else if (wc_ff == '0) begin
               push_cmd.kind = KIND_EMPTY;
            end else begin
               push_cmd.kind = (sub_ff == 7'd0) ? KIND_REG : KIND_RAW;
               push_cmd.count = wc_ff;
               busy_in = 1'b1;
            end
            wc_in = '0;
            bc_in = 8'd0;
            hok_in = 1'b1;
            sub_in = 7'd0;
            acc_in = 32'd0;
            pos_in = 3'd0;
            ovf_in = 1'b0;
         end else begin
            priority if (bc_ff < HDR_LEN) begin
               if (req_data_byte != hdr_byte(bc_ff[2:0])) begin
                  hok_in = 1'b0;
               end
               bc_in = bc_ff + 8'd1;
            end else if (bc_ff == HDR_LEN) begin
               sub_in = lo7;
               bc_in = bc_ff + 8'd1;
            end else if (pos_ff == 3'd0 && wc_ff >= CNT_W'(MAX_WORDS)) begin
               ovf_in = 1'b1;
               push = 1'b1;
               push_cmd.kind = KIND_LONG;
            end else begin
               if (pos_ff == 3'd4) begin
                  wr.en = 1'b1;
                  wc_in = wc_ff + CNT_W'(1);
                  acc_in = 32'd0;
                  pos_in = 3'd0;
               end else begin
                  acc_in = acc_next;
                  pos_in = pos_ff + 3'd1;
               end
               if (bc_ff != 8'd255) begin
                  bc_in = bc_ff + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff <= '0;
         bc_ff <= 8'd0;
         hok_ff <= 1'b1;
         sub_ff <= 7'd0;
         acc_ff <= 32'd0;
         pos_ff <= 3'd0;
         ovf_ff <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         wc_ff <= wc_in;
         bc_ff <= bc_in;
         hok_ff <= hok_in;
         sub_ff <= sub_in;
         acc_ff <= acc_in;
         pos_ff <= pos_in;
         ovf_ff <= ovf_in;
         busy_ff <= busy_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/sxrfd_queue.sv @@
`default_nettype none
module sxrfd_queue
   import sxrfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty,
   output logic         full
);

   cmd_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign empty = (cnt_ff == '0);
   assign full = (cnt_ff == (QPTR_W + 1)'(QDEPTH));
   assign head = q_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wp_in = do_push ? wp_ff + QPTR_W'(1) : wp_ff;
      rp_in = do_pop ? rp_ff + QPTR_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/sxrfd_back.sv @@
`default_nettype none
module sxrfd_back
   import sxrfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     head,
   input  wire logic        q_empty,
   output logic             pop,
   input  wire wr_type      wr,
   output logic             drain_done,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [6:0]       rsp_sub_id,
   output logic [31:0]      rsp_word,
   output logic [14:0]      rsp_reg_number,
   output logic [15:0]      rsp_reg_value,
   output logic             rsp_parity_bad,
   output logic             rsp_last
);

   typedef enum logic [1:0] {
      B_IDLE  = 2'b01,
      B_DRAIN = 2'b10
   } bstate_type;

   logic [31:0]      mem [MAX_WORDS];

   bstate_type       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   kind_type         dkind_ff, dkind_in;
   logic [6:0]       dsub_ff, dsub_in;

   logic             r_vld_ff, r_vld_in;
   kind_type         r_kind_ff;
   logic [6:0]       r_sub_ff;
   logic             r_last_ff;
   logic             r_mem_ff;
   logic [31:0]      rd_data_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff;
   logic [6:0]       rsp_sub_id_ff;
   logic [31:0]      rsp_word_ff;
   logic [14:0]      rsp_reg_number_ff;
   logic [15:0]      rsp_reg_value_ff;
   logic             rsp_parity_bad_ff;
   logic             rsp_last_ff;

   logic             out_free;
   logic             out_adv;
   logic             r_free;
   logic             head_drain;
   logic             issue_one;
   logic             issue_mem;
   logic             idx_last;
   logic             is_reg;
   logic [31:0]      word_sel;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_adv = r_vld_ff && out_free;
   assign r_free = !r_vld_ff || out_adv;
   assign head_drain = (head.kind == KIND_REG) || (head.kind == KIND_RAW);
   assign idx_last = (idx_ff == cnt_ff - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      dkind_in = dkind_ff;
      dsub_in = dsub_ff;
      pop = 1'b0;
      issue_one = 1'b0;
      issue_mem = 1'b0;
      drain_done = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (head_drain) begin
                  pop = 1'b1;
                  state_in = B_DRAIN;
                  idx_in = '0;
                  cnt_in = head.count;
                  dkind_in = head.kind;
                  dsub_in = head.sub_id;
               end else if (r_free) begin
                  pop = 1'b1;
                  issue_one = 1'b1;
               end
            end
         end
         B_DRAIN: begin
            if (r_free) begin
               issue_mem = 1'b1;
               idx_in = idx_ff + CNT_W'(1);
               if (idx_last) begin
                  drain_done = 1'b1;
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      r_vld_in = r_vld_ff;
      if (issue_one || issue_mem) begin
         r_vld_in = 1'b1;
      end else if (out_adv) begin
         r_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (issue_mem) begin
         rd_data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (issue_one) begin
         r_kind_ff <= head.kind;
         r_sub_ff <= head.sub_id;
         r_last_ff <= 1'b1;
         r_mem_ff <= 1'b0;
      end else if (issue_mem) begin
         r_kind_ff <= dkind_ff;
         r_sub_ff <= dsub_ff;
         r_last_ff <= idx_last;
         r_mem_ff <= 1'b1;
      end
   end

   assign word_sel = r_mem_ff ? rd_data_ff : 32'd0;
   assign is_reg = (r_kind_ff == KIND_REG);
   assign rsp_valid_in = out_adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_kind_ff <= r_kind_ff;
         rsp_sub_id_ff <= r_sub_ff;
         rsp_word_ff <= word_sel;
         rsp_reg_number_ff <= is_reg ? word_sel[30:16] : 15'd0;
         rsp_reg_value_ff <= is_reg ? word_sel[15:0] : 16'd0;
         rsp_parity_bad_ff <= is_reg ? ~(^word_sel) : 1'b0;
         rsp_last_ff <= r_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         idx_ff <= '0;
         cnt_ff <= '0;
         dkind_ff <= KIND_RAW;
         dsub_ff <= 7'd0;
         r_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         dkind_ff <= dkind_in;
         dsub_ff <= dsub_in;
         r_vld_ff <= r_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_sub_id = rsp_sub_id_ff;
   assign rsp_word = rsp_word_ff;
   assign rsp_reg_number = rsp_reg_number_ff;
   assign rsp_reg_value = rsp_reg_value_ff;
   assign rsp_parity_bad = rsp_parity_bad_ff;
   assign rsp_last = rsp_last_ff;

endmodule
`default_nettype wire

@@ rtl/sysex_register_frame_decoder_core.sv @@
// path: a result passes through the command queue, the back end's read stage and the output register;
//   a frame's words leave the word store after its closing byte, one per cycle unless the output stalls
// throughput: one item per cycle; after a frame that releases words the input stalls while the back end
//   reads them out of the word store, longer under output stall or with commands still queued, and also
//   while the 4-entry queue is full
// reset: synchronous, active high; clears frame state, queue and output valid; word store is not cleared
`default_nettype none
module sysex_register_frame_decoder_core
   import sxrfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [6:0]       rsp_sub_id,
   output logic [31:0]      rsp_word,
   output logic [14:0]      rsp_reg_number,
   output logic [15:0]      rsp_reg_value,
   output logic             rsp_parity_bad,
   output logic             rsp_last
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    q_empty;
   logic    q_full;
   logic    drain_done;
   wr_type  wr;
   logic    busy;

   sxrfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_cmd      (push_cmd),
      .q_full        (q_full),
      .drain_done    (drain_done),
      .wr            (wr),
      .busy          (busy)
   );

   sxrfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   sxrfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .pop            (pop),
      .wr             (wr),
      .drain_done     (drain_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_sub_id     (rsp_sub_id),
      .rsp_word       (rsp_word),
      .rsp_reg_number (rsp_reg_number),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_parity_bad (rsp_parity_bad),
      .rsp_last       (rsp_last)
   );

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !q_full)
      else $error("command pushed into full queue");
   a_drain_busy: assert property (@(posedge clock) disable iff (reset) drain_done |-> busy)
      else $error("drain finished with front not waiting");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset) wr.en |-> !busy)
      else $error("word store written during drain");
   a_drain_lock: assert property (@(posedge clock) disable iff (reset)
      (push && (push_cmd.kind == KIND_REG || push_cmd.kind == KIND_RAW)) |=> req_stall)
      else $error("input not held after frame release");
`endif

endmodule
`default_nettype wire

@@ bench/sysex_register_frame_decoder_core_test.sv @@
module sysex_register_frame_decoder_core_test;
   import sxrfd_pkg::*;

   localparam logic [39:0] FRAME_HEADER = 40'hf0_00_20_0d_10;

   typedef enum int {
      SHAPE_GOOD,
      SHAPE_PARTIAL,
      SHAPE_BAD_HEADER,
      SHAPE_CUT,
      SHAPE_EARLY_EOX,
      SHAPE_NOISE,
      SHAPE_FULL,
      SHAPE_OVERLONG_CLOSED,
      SHAPE_OVERLONG_CUT
   } frame_shape_t;

   typedef struct packed {
      logic [7:0] data;
      logic       hold;
   } sysex_slot_t;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  sub_id;
      logic [31:0] word;
      logic [14:0] reg_number;
      logic [15:0] reg_value;
      logic        parity_bad;
      logic        last;
   } rsp_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [6:0]  rsp_sub_id;
   logic [31:0] rsp_word;
   logic [14:0] rsp_reg_number;
   logic [15:0] rsp_reg_value;
   logic        rsp_parity_bad;
   logic        rsp_last;

   sysex_register_frame_decoder_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_sub_id     (rsp_sub_id),
      .rsp_word       (rsp_word),
      .rsp_reg_number (rsp_reg_number),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_parity_bad (rsp_parity_bad),
      .rsp_last       (rsp_last)
   );

   always #4 clock = ~clock;

   sysex_slot_t sysex_bytes [$];
   rsp_item_t   decoded_results [$];

   int taken_cnt = 0;
   int sent_cnt = 0;
   int errors = 0;
   int checked = 0;
   int reg_words = 0;
   int raw_words = 0;
   int frame_reports = 0;
   int frames_built = 0;

   // decoder state
   logic [31:0] frame_words [MAX_WORDS];
   int          words_seen;
   int          frame_bytes;
   int          group_fill;
   bit          header_match;
   bit          frame_overflow;
   logic [6:0]  frame_sub;
   logic [31:0] partial_word;

   function automatic void restart_frame();
      words_seen = 0;
      frame_bytes = 0;
      group_fill = 0;
      header_match = 1'b1;
      frame_overflow = 1'b0;
      frame_sub = 7'd0;
      partial_word = 32'd0;
   endfunction

   function automatic void report(kind_type kind, logic [31:0] w, bit split);
      rsp_item_t r;
      r.kind = kind;
      r.sub_id = frame_sub;
      r.word = w;
      r.reg_number = split ? w[30:16] : 15'd0;
      r.reg_value = split ? w[15:0] : 16'd0;
      r.parity_bad = split ? ~^w : 1'b0;
      r.last = 1'b0;
      decoded_results.push_back(r);
   endfunction

   function automatic void absorb_byte(logic [7:0] b);
      logic [63:0] shifted;
      if (frame_bytes < 5) begin
         if (b != FRAME_HEADER[39 - 8*frame_bytes -: 8])
            header_match = 1'b0;
      end else if (frame_bytes == 5) begin
         frame_sub = b[6:0];
      end else begin
         if (group_fill == 0 && words_seen >= MAX_WORDS) begin
            frame_overflow = 1'b1;
            report(KIND_LONG, 32'd0, 1'b0);
            return;
         end
         shifted = {57'd0, b[6:0]} << (7 * group_fill);
         partial_word = partial_word | shifted[31:0];
         group_fill++;
         if (group_fill == 5) begin
            frame_words[words_seen] = partial_word;
            words_seen++;
            partial_word = 32'd0;
            group_fill = 0;
         end
      end
      if (frame_bytes < 255)
         frame_bytes++;
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      int prior_count;
      rsp_item_t r;
      prior_count = decoded_results.size();
      if (b == BYTE_SOX) begin
         if (frame_bytes > 0 || frame_overflow) begin
            report(KIND_INCOMPLETE, 32'd0, 1'b0);
            restart_frame();
         end
         absorb_byte(b);
      end else if (frame_overflow) begin
         if (b == BYTE_EOX)
            restart_frame();
      end else if (b == BYTE_EOX) begin
         if (!header_match || frame_bytes < 6 || group_fill != 0)
            report(KIND_BAD, 32'd0, 1'b0);
         else if (words_seen == 0)
            report(KIND_EMPTY, 32'd0, 1'b0);
         else
            for (int i = 0; i < words_seen; i++)
               report(frame_sub == 7'd0 ? KIND_REG : KIND_RAW, frame_words[i],
                      frame_sub == 7'd0);
         restart_frame();
      end else begin
         absorb_byte(b);
      end
      if (decoded_results.size() > prior_count) begin
         r = decoded_results.pop_back();
         r.last = 1'b1;
         decoded_results.push_back(r);
      end
   endfunction

   // stimulus helpers
   function automatic void queue_byte(logic [7:0] b);
      sysex_bytes.push_back({b, 1'b0});
   endfunction

   function automatic logic [7:0] content_byte();
      logic [7:0] b;
      b = BYTE_SOX;
      while (b == BYTE_SOX || b == BYTE_EOX)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic add_frame(input frame_shape_t shape);
      int i;
      int hdr_len;
      int bad_pos;
      int n_words;
      int tail;
      logic [7:0] b;
      logic [7:0] good;
      frames_built++;
      if (shape == SHAPE_NOISE) begin
         repeat ($urandom_range(1, 6))
            queue_byte(8'($urandom_range(0, 255)));
         return;
      end
      hdr_len = (shape == SHAPE_EARLY_EOX) ? $urandom_range(1, 5) : 5;
      bad_pos = (shape == SHAPE_BAD_HEADER) ? $urandom_range(0, 4) : -1;
      for (i = 0; i < hdr_len; i++) begin
         b = FRAME_HEADER[39 - 8*i -: 8];
         if (i == bad_pos) begin
            good = b;
            while (b == good)
               b = content_byte();
         end
         queue_byte(b);
      end
      if (shape == SHAPE_EARLY_EOX) begin
         queue_byte(BYTE_EOX);
         return;
      end
      b = content_byte();
      if ($urandom_range(0, 1))
         b[6:0] = 7'h00;
      queue_byte(b);
      case (shape)
         SHAPE_FULL, SHAPE_OVERLONG_CLOSED, SHAPE_OVERLONG_CUT: n_words = MAX_WORDS;
         SHAPE_GOOD: begin
            n_words = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 8);
         end
         default: n_words = $urandom_range(0, 2);
      endcase
      repeat (n_words * 5)
         queue_byte(content_byte());
      case (shape)
         SHAPE_PARTIAL, SHAPE_OVERLONG_CLOSED, SHAPE_OVERLONG_CUT: tail = $urandom_range(1, 4);
         SHAPE_CUT: tail = $urandom_range(0, 4);
         default: tail = 0;
      endcase
      repeat (tail)
         queue_byte(content_byte());
      if (shape != SHAPE_CUT && shape != SHAPE_OVERLONG_CUT)
         queue_byte(BYTE_EOX);
   endtask

   function automatic int idle_length(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver
   int gap_left = 0;
   int send_calm = 0;

   always @(negedge clock) begin
      sysex_slot_t slot;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && taken_cnt != sent_cnt)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (sysex_bytes.size() > 0 && sysex_bytes[0].hold) begin
            req_valid <= 1'b0;
            if (decoded_results.size() == 0)
               slot = sysex_bytes.pop_front();
         end else if (sysex_bytes.size() > 0) begin
            slot = sysex_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= slot.data;
            sent_cnt++;
            gap_left = idle_length(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   int stall_left = 0;
   int stall_calm = 0;

   always @(negedge clock) begin
      int n;
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         n = idle_length(stall_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            stall_left = n - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_t want;
      rsp_item_t got;
      if (!reset && req_valid && !req_stall) begin
         decode_byte(req_data_byte);
         taken_cnt++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = kind_type'(rsp_kind);
         got.sub_id = rsp_sub_id;
         got.word = rsp_word;
         got.reg_number = rsp_reg_number;
         got.reg_value = rsp_reg_value;
         got.parity_bad = rsp_parity_bad;
         got.last = rsp_last;
         if (decoded_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected item: kind %0d sub %0d word %h", got.kind, got.sub_id,
                        got.word);
         end else begin
            want = decoded_results.pop_front();
            checked++;
            if (want.kind == KIND_REG)
               reg_words++;
            else if (want.kind == KIND_RAW)
               raw_words++;
            else
               frame_reports++;
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: expected kind %0d sub %0d word %h reg %h val %h ",
                            "par %b last %b, got kind %0d sub %0d word %h reg %h val %h ",
                            "par %b last %b"},
                           want.kind, want.sub_id, want.word, want.reg_number,
                           want.reg_value, want.parity_bad, want.last,
                           got.kind, got.sub_id, got.word, got.reg_number,
                           got.reg_value, got.parity_bad, got.last);
            end
         end
      end
   end

   initial begin
      int f;
      int r;
      logic [7:0] opening [24];
      restart_frame();

      // lone close, stray byte, empty frame, dropped frame then a register word
      opening = '{8'hf7, 8'h55, 8'hf7,
                  8'hf0, 8'h00, 8'h20, 8'h0d, 8'h10, 8'hff, 8'hf7,
                  8'hf0, 8'h00, 8'hf0, 8'h00, 8'h20, 8'h0d, 8'h10, 8'h80,
                  8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hf7};
      foreach (opening[i])
         queue_byte(opening[i]);
      sysex_bytes.push_back({8'h00, 1'b1});

      for (f = 0; f < 7; f++) begin
         if (f == 3) begin
            // one frame at the word limit, released or overrunning
            sysex_bytes.push_back({8'h00, 1'b1});
            r = $urandom_range(0, 2);
            if (r == 0)
               add_frame(SHAPE_FULL);
            else if (r == 1)
               add_frame(SHAPE_OVERLONG_CLOSED);
            else
               add_frame(SHAPE_OVERLONG_CUT);
            add_frame(SHAPE_GOOD);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55)
               add_frame(SHAPE_GOOD);
            else if (r < 65)
               add_frame(SHAPE_PARTIAL);
            else if (r < 75)
               add_frame(SHAPE_BAD_HEADER);
            else if (r < 85)
               add_frame(SHAPE_CUT);
            else if (r < 92)
               add_frame(SHAPE_EARLY_EOX);
            else
               add_frame(SHAPE_NOISE);
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sysex_bytes.size() != 0 || taken_cnt != sent_cnt)
         @(posedge clock);
      while (decoded_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      $display("%0d bytes in %0d generated frames; %0d items checked", taken_cnt,
               frames_built, checked);
      $display("%0d register words, %0d raw words, %0d frame reports, %0d failures",
               reg_words, raw_words, frame_reports, errors);
      if (errors == 0)
         $display("[sysex_register_frame_decoder_core] OK");
      else
         $display("[sysex_register_frame_decoder_core] ERROR");
      $finish;
   end

   initial begin
      #20000000;
      $display("[sysex_register_frame_decoder_core] ERROR");
      $finish;
   end

endmodule
